// File: hw/rtl/necir_pkg.sv
// Shared types and constants for the NEC IR frame decoder.
package necir_pkg;

  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned EDGE_W     = 32;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned CFG_W      = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CNT_W      = $clog2(FRAME_BITS);

  localparam logic [CFG_W-1:0] ZeroMinRst = CFG_W'(40500);
  localparam logic [CFG_W-1:0] ZeroMaxRst = CFG_W'(49500);
  localparam logic [CFG_W-1:0] OneMinRst  = CFG_W'(81000);
  localparam logic [CFG_W-1:0] OneMaxRst  = CFG_W'(99000);
  localparam logic [CFG_W-1:0] LeadMinRst = CFG_W'(520000);
  localparam logic [CFG_W-1:0] LeadMaxRst = CFG_W'(560000);

  localparam logic [CNT_W:0] FrameLast = (CNT_W+1)'(FRAME_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_MIN = 3'd0,
    REG_ZERO_MAX = 3'd1,
    REG_ONE_MIN  = 3'd2,
    REG_ONE_MAX  = 3'd3,
    REG_LEAD_MIN = 3'd4,
    REG_LEAD_MAX = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_LEAD = 2'd1,
    CLS_ZERO = 2'd2,
    CLS_ONE  = 2'd3
  } pulse_cls_e;

  typedef struct packed {
    logic [CFG_W-1:0] zero_min;
    logic [CFG_W-1:0] zero_max;
    logic [CFG_W-1:0] one_min;
    logic [CFG_W-1:0] one_max;
    logic [CFG_W-1:0] lead_min;
    logic [CFG_W-1:0] lead_max;
  } cfg_t;

endpackage

// File: hw/rtl/necir_cfg.sv
// Timing window registers with a plain write port.
module necir_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [necir_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [necir_pkg::CFG_W-1:0]      cfg_data_i,
  output necir_pkg::cfg_t                  cfg_o
);

  necir_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (necir_pkg::cfg_idx_e'(cfg_idx_i))
        necir_pkg::REG_ZERO_MIN: cfg_d.zero_min = cfg_data_i;
        necir_pkg::REG_ZERO_MAX: cfg_d.zero_max = cfg_data_i;
        necir_pkg::REG_ONE_MIN:  cfg_d.one_min  = cfg_data_i;
        necir_pkg::REG_ONE_MAX:  cfg_d.one_max  = cfg_data_i;
        necir_pkg::REG_LEAD_MIN: cfg_d.lead_min = cfg_data_i;
        necir_pkg::REG_LEAD_MAX: cfg_d.lead_max = cfg_data_i;
        default: ;  // unused indexes drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_min <= necir_pkg::ZeroMinRst;
      cfg_q.zero_max <= necir_pkg::ZeroMaxRst;
      cfg_q.one_min  <= necir_pkg::OneMinRst;
      cfg_q.one_max  <= necir_pkg::OneMaxRst;
      cfg_q.lead_min <= necir_pkg::LeadMinRst;
      cfg_q.lead_max <= necir_pkg::LeadMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/necir_classify.sv
// Pulse width classifier: preamble, zero, one or nothing.
module necir_classify (
  input  logic [necir_pkg::EDGE_W-1:0] width_i,
  input  necir_pkg::cfg_t              cfg_i,
  output necir_pkg::pulse_cls_e        cls_o
);

  logic [necir_pkg::EDGE_W-1:0] zmin, zmax, omin, omax, lmin, lmax;
  logic is_lead, is_zero, is_one;

  assign zmin = necir_pkg::EDGE_W'(cfg_i.zero_min);
  assign zmax = necir_pkg::EDGE_W'(cfg_i.zero_max);
  assign omin = necir_pkg::EDGE_W'(cfg_i.one_min);
  assign omax = necir_pkg::EDGE_W'(cfg_i.one_max);
  assign lmin = necir_pkg::EDGE_W'(cfg_i.lead_min);
  assign lmax = necir_pkg::EDGE_W'(cfg_i.lead_max);

  // preamble bounds are exclusive, bit windows inclusive
  assign is_lead = (width_i > lmin) && (width_i < lmax);
  assign is_zero = (width_i >= zmin) && (width_i <= zmax);
  assign is_one  = (width_i >= omin) && (width_i <= omax);

  always_comb begin
    if (is_lead) begin
      cls_o = necir_pkg::CLS_LEAD;
    end else if (is_zero) begin
      cls_o = necir_pkg::CLS_ZERO;
    end else if (is_one) begin
      cls_o = necir_pkg::CLS_ONE;
    end else begin
      cls_o = necir_pkg::CLS_NONE;
    end
  end

endmodule

// File: hw/rtl/necir_core.sv
// Edge input register, frame shift state and result register.
module necir_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  necir_pkg::cfg_t               cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [necir_pkg::EDGE_W-1:0]  edge_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [necir_pkg::CODE_W-1:0]  code_o
);

  logic                              in_valid_q, in_valid_d;
  logic [necir_pkg::EDGE_W-1:0]      edge_q, edge_d;
  logic [necir_pkg::EDGE_W-1:0]      prev_edge_q, prev_edge_d;
  logic [necir_pkg::FRAME_BITS-1:0]  shift_bits_q, shift_bits_d;
  logic [necir_pkg::CNT_W-1:0]       bits_seen_q, bits_seen_d;
  logic                              out_valid_q, out_valid_d;
  logic [necir_pkg::CODE_W-1:0]      code_q, code_d;

  logic                              advance, in_take, emit;
  logic [necir_pkg::EDGE_W-1:0]      width;
  logic [necir_pkg::FRAME_BITS-1:0]  shifted;
  logic [necir_pkg::CNT_W:0]         count;
  necir_pkg::pulse_cls_e             cls;

  // staged item moves on when the result slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign width = edge_q - prev_edge_q;

  necir_classify u_classify (
    .width_i (width),
    .cfg_i   (cfg_i),
    .cls_o   (cls)
  );

  assign shifted = {shift_bits_q[necir_pkg::FRAME_BITS-2:0], (cls == necir_pkg::CLS_ONE)};
  assign count   = {1'b0, bits_seen_q} + (necir_pkg::CNT_W+1)'(1);
  assign emit    = advance && ((cls == necir_pkg::CLS_ZERO) || (cls == necir_pkg::CLS_ONE))
                   && (count == necir_pkg::FrameLast);

  always_comb begin
    in_valid_d   = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    edge_d       = in_take ? edge_time_i : edge_q;
    prev_edge_d  = prev_edge_q;
    shift_bits_d = shift_bits_q;
    bits_seen_d  = bits_seen_q;
    out_valid_d  = out_valid_q && out_stall_i;
    code_d       = code_q;
    if (advance) begin
      prev_edge_d = edge_q;
      case (cls) inside
        necir_pkg::CLS_LEAD: begin
          shift_bits_d = '0;
          bits_seen_d  = '0;
        end
        necir_pkg::CLS_ZERO, necir_pkg::CLS_ONE: begin
          if (emit) begin
            shift_bits_d = '0;
            bits_seen_d  = '0;
            out_valid_d  = 1'b1;
            code_d       = necir_pkg::CODE_W'(shifted);
          end else begin
            shift_bits_d = shifted;
            bits_seen_d  = count[necir_pkg::CNT_W-1:0];
          end
        end
        default: ;  // width fits no window
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      prev_edge_q  <= '0;
      shift_bits_q <= '0;
      bits_seen_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      prev_edge_q  <= prev_edge_d;
      shift_bits_q <= shift_bits_d;
      bits_seen_q  <= bits_seen_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q <= edge_d;
    code_q <= code_d;
  end

  assign out_valid_o = out_valid_q;
  assign code_o      = code_q;

`ifndef SYNTHESIS
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (shift_bits_q == '0) && (bits_seen_q == '0) && out_valid_q)
    else $error("frame state not cleared after emit");

  a_prev_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (prev_edge_q == $past(edge_q)))
    else $error("previous edge not updated from staged item");

  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && out_stall_i) |=> (in_valid_q && $stable(edge_q)))
    else $error("staged item lost while result stalled");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(shift_bits_q) && $stable(bits_seen_q) && $stable(prev_edge_q)))
    else $error("frame state changed without an item");
`endif

endmodule

// File: hw/rtl/nec_ir_frame_decoder.sv
// Top level of the NEC IR frame decoder.
// Feed the counter value captured at every falling IR edge. Each item is
// registered, then its pulse width (difference from the previous edge,
// modulo 2^32) is classified against the six window registers and folded
// into the frame state once the result slot is free or draining; one item
// is taken per cycle unless the input stage stalls. A finished code is
// registered as its last item is folded in; the result register holds the
// 32-bit code (first bit in the MSB) while the sink stalls, and only then
// does the input stage back up. The user must write windows through the
// config port while no item is in flight; the block does not enforce it.
module nec_ir_frame_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [necir_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [necir_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [necir_pkg::EDGE_W-1:0]  edge_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [necir_pkg::CODE_W-1:0]  code_o
);

  necir_pkg::cfg_t cfg;

  necir_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  necir_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .edge_time_i (edge_time_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_o      (code_o)
  );

endmodule
